// ===== rtl/clnw_pkg.sv =====
// Shared types and constants of the character LCD nibble writer.
`default_nettype none
package clnw_pkg;

  localparam int QUEUE_DEPTH = 2;

  // request kinds
  localparam logic REQ_INIT = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_LINE_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_WRAP_COMMAND  = 2'd1;
  localparam logic [1:0] CFG_BYTE_WAIT     = 2'd2;
  localparam logic [1:0] CFG_CLEAR_WAIT    = 2'd3;

  localparam logic [5:0]  LINE_LENGTH_RST  = 6'd16;
  localparam logic [7:0]  WRAP_COMMAND_RST = 8'hA8;
  localparam logic [7:0]  BYTE_WAIT_RST    = 8'd40;
  localparam logic [11:0] CLEAR_WAIT_RST   = 12'd1640;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;

  localparam logic [5:0]  POS_MAX  = 6'd63;
  localparam logic [11:0] WAIT_MAX = 12'hFFF;

  typedef struct packed {
    logic [5:0]  line_length;
    logic [7:0]  wrap_command;
    logic [7:0]  byte_wait_us;
    logic [11:0] clear_wait_us;
  } cfg_t;

  // one classified request: init sequence, or a character with optional wrap
  typedef struct packed {
    logic       init;
    logic [7:0] char_code;
    logic       wrap;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/clnw_req_if.sv =====
// Request channel: one init or text character request.
`default_nettype none
interface clnw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic       text_end;

  modport source (output valid, output req_type, output char_code, output text_end,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input text_end,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/clnw_pin_if.sv =====
// Pin phase channel: one LCD bus phase per transfer.
`default_nettype none
interface clnw_pin_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable_line;
  logic [3:0]  data_nibble;
  logic [11:0] wait_us;
  logic        run_last;

  modport source (output valid, output reg_select, output enable_line,
                  output data_nibble, output wait_us, output run_last, input ready);
  modport sink (input valid, input reg_select, input enable_line,
                input data_nibble, input wait_us, input run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/clnw_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface clnw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/char_lcd_nibble_writer_core.sv =====
// Top level of the character LCD nibble writer: config registers and wiring.
//
//  channel  role    carries
//  req      sink    req_type, char_code, text_end
//  pins     source  reg_select, enable_line, data_nibble, wait_us, run_last
//  cfg      sink    index, data (always ready)
//
// One bus phase leaves per cycle while pins is ready; the back-end phase sequencer
// sets four phases per character, eight with the wrap command, sixteen per init.
// Requests queue ahead while the sequencer runs; the front stalls only when full.
// A stalled pins channel holds the sequencer; rst is synchronous and clears
// the queue, the line position and the config registers to their defaults.
`default_nettype none
module char_lcd_nibble_writer_core
  import clnw_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst,
  clnw_req_if.sink   req,
  clnw_pin_if.source pins,
  clnw_cfg_if.sink   cfg
);

  cfg_t cfg_regs;
  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t pop_job;
  logic q_not_empty;
  logic busy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.line_length   <= LINE_LENGTH_RST;
      cfg_regs.wrap_command  <= WRAP_COMMAND_RST;
      cfg_regs.byte_wait_us  <= BYTE_WAIT_RST;
      cfg_regs.clear_wait_us <= CLEAR_WAIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LINE_LENGTH:  cfg_regs.line_length   <= cfg.data[5:0];
        CFG_WRAP_COMMAND: cfg_regs.wrap_command  <= cfg.data[7:0];
        CFG_BYTE_WAIT:    cfg_regs.byte_wait_us  <= cfg.data[7:0];
        CFG_CLEAR_WAIT:   cfg_regs.clear_wait_us <= cfg.data;
        default: ;
      endcase
    end
  end

  clnw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .line_length (cfg_regs.line_length),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  clnw_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty)
  );

  clnw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_regs),
    .q_not_empty (q_not_empty),
    .q_job       (pop_job),
    .pop         (pop),
    .busy        (busy),
    .pins        (pins)
  );

  // a queued request never waits on an idle sequencer
  a_no_idle_wait: assert property (@(posedge clk) disable iff (rst)
    (q_not_empty && !busy) |=> busy)
    else $error("sequencer idle with queued request");

  // only the settle phase (enable low) may carry a wait
  a_wait_on_low: assert property (@(posedge clk) disable iff (rst)
    (pins.valid && pins.enable_line) |-> (pins.wait_us == '0))
    else $error("wait on enable-high phase");

  // the last phase of a request is always an enable-low phase
  a_last_low: assert property (@(posedge clk) disable iff (rst)
    (pins.valid && pins.run_last) |-> !pins.enable_line)
    else $error("run_last on enable-high phase");

endmodule
`default_nettype wire

// ===== rtl/clnw_front.sv =====
// Front end: accepts requests, tracks line position, decides on the wrap command.
`default_nettype none
module clnw_front
  import clnw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  clnw_req_if.sink        req,
  input  wire logic [5:0] line_length,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  logic [5:0] line_position;
  logic [5:0] line_position_next;
  logic       wrap_sent;
  logic       wrap_sent_next;
  logic [5:0] pos_inc;
  logic       do_wrap;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    pos_inc = (line_position < POS_MAX) ? line_position + 6'd1 : line_position;
    do_wrap = !wrap_sent && ((pos_inc >= line_length) || req.text_end);

    push_job.init      = (req.req_type == REQ_INIT);
    push_job.char_code = req.char_code;
    push_job.wrap      = (req.req_type == REQ_TEXT) && do_wrap;

    line_position_next = line_position;
    wrap_sent_next     = wrap_sent;
    if (push) begin
      if (req.req_type == REQ_INIT || req.text_end) begin
        line_position_next = '0;
        wrap_sent_next     = 1'b0;
      end else begin
        line_position_next = pos_inc;
        wrap_sent_next     = wrap_sent || do_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      wrap_sent     <= 1'b0;
    end else begin
      line_position <= line_position_next;
      wrap_sent     <= wrap_sent_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/clnw_queue.sv =====
// Short FIFO of classified requests between front and back end.
`default_nettype none
module clnw_queue
  import clnw_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      not_empty
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Depth - 1);

  job_t             store [Depth];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(Depth));
  assign not_empty = (count != '0);
  assign pop_job   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/clnw_back.sv =====
// Back end: phase sequencer, four bus phases per byte, with output register.
`default_nettype none
module clnw_back
  import clnw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_not_empty,
  input  wire job_t q_job,
  output logic      pop,
  output logic      busy,
  clnw_pin_if.source pins
);

  job_t       job;
  logic       active;
  logic [1:0] byte_idx;
  logic [1:0] phase;

  logic        advance;
  logic        last_byte;
  logic        last_phase;
  logic [7:0]  cur_byte;
  logic        cur_rs;
  logic [12:0] clear_sum;
  logic [11:0] clear_wait;
  logic [11:0] cur_wait;

  assign busy = active;

  always_comb begin
    advance    = active && (!pins.valid || pins.ready);
    last_byte  = job.init ? (byte_idx == 2'd3) : (job.wrap ? (byte_idx == 2'd1)
                                                           : (byte_idx == 2'd0));
    last_phase = last_byte && (phase == 2'd3);
    pop        = q_not_empty && (!active || (advance && last_phase));

    clear_sum  = {5'b0, cfg.byte_wait_us} + {1'b0, cfg.clear_wait_us};
    clear_wait = clear_sum[12] ? WAIT_MAX : clear_sum[11:0];

    cur_rs = 1'b0;
    if (job.init) begin
      unique case (byte_idx)
        2'd0:    cur_byte = CMD_FUNCTION_SET;
        2'd1:    cur_byte = CMD_ENTRY_MODE;
        2'd2:    cur_byte = CMD_DISPLAY_ON;
        default: cur_byte = CMD_CLEAR;
      endcase
    end else if (byte_idx == 2'd0) begin
      cur_byte = job.char_code;
      cur_rs   = 1'b1;
    end else begin
      cur_byte = cfg.wrap_command;
    end

    if (phase != 2'd3)                       cur_wait = '0;
    else if (job.init && byte_idx == 2'd3)   cur_wait = clear_wait;
    else                                     cur_wait = {4'b0, cfg.byte_wait_us};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      pins.valid <= 1'b0;
    end else begin
      if (advance)         pins.valid <= 1'b1;
      else if (pins.ready) pins.valid <= 1'b0;

      if (pop) begin
        active <= 1'b1;
      end else if (advance && last_phase) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job      <= q_job;
      byte_idx <= '0;
      phase    <= '0;
    end else if (advance) begin
      phase <= phase + 2'd1;
      if (phase == 2'd3) byte_idx <= byte_idx + 2'd1;
    end
    if (advance) begin
      pins.reg_select  <= cur_rs;
      pins.enable_line <= !phase[0];
      pins.data_nibble <= phase[1] ? cur_byte[3:0] : cur_byte[7:4];
      pins.wait_us     <= cur_wait;
      pins.run_last    <= last_phase;
    end
  end

endmodule
`default_nettype wire
